@@ sv/infix_to_postfix_converter_assert.svh @@
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_assert.svh
// assertion macros used by the converter's checker
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ITP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// next-cycle implication, disabled in reset
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

@@ sv/itp_pkg.sv @@
// ---------------------------------------------------------------------------
// itp_pkg
// types and constants of the infix to postfix converter
// ---------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int KIND_W = 3;
    localparam int PRIO_W = 4;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_NUM     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POSTFIX = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PREFIX  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BINARY  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd6;

    localparam logic [STAT_W-1:0] STAT_TOKEN     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNMATCHED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD       = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

@@ sv/itp_cell.sv @@
// ---------------------------------------------------------------------------
// itp_cell
// one stack slot: takes the upper neighbor on push, the lower one on pop
// ---------------------------------------------------------------------------
module itp_cell (
    input  logic            aclk,
    input  itp_pkg::stk_op_t op_i,
    input  itp_pkg::entry_t  upper_i,
    input  itp_pkg::entry_t  lower_i,
    output itp_pkg::entry_t  entry_o
);
    import itp_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (op_i.push) begin
            entry_next = upper_i;
        end else if (op_i.pop) begin
            entry_next = lower_i;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_o = entry_reg;

endmodule

@@ sv/itp_stack.sv @@
// ---------------------------------------------------------------------------
// itp_stack
// operator stack as a chain of shifting cells, top in cell zero
// ---------------------------------------------------------------------------
module itp_stack (
    input  logic             aclk,
    input  itp_pkg::stk_op_t op_i,
    input  itp_pkg::entry_t  push_entry_i,
    output itp_pkg::entry_t  top_o,
    output itp_pkg::entry_t  next_o
);
    import itp_pkg::*;

    entry_t ent [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        entry_t upper;
        entry_t lower;

        if (g == 0) begin : g_first
            assign upper = push_entry_i;
        end else begin : g_mid_up
            assign upper = ent[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign lower = '0;
        end else begin : g_mid_dn
            assign lower = ent[g+1];
        end

        itp_cell u_cell (
            .aclk    (aclk),
            .op_i    (op_i),
            .upper_i (upper),
            .lower_i (lower),
            .entry_o (ent[g])
        );
    end

    assign top_o  = ent[0];
    assign next_o = ent[1];

endmodule

@@ sv/infix_to_postfix_converter.sv @@
// an accepted token is registered; each step that emits loads its result into the output register
// a new token is taken only in idle, once the last one is done; every token takes at least one step
// a step pops, pushes or emits, save in a flush of an empty stack; a flush of n > 0 entries takes n steps
// steps that emit stall while the output register holds an untaken beat
// reset: synchronous active-low aresetn empties the stack and clears both channels
// ---------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard converter with a bounded operator stack built from cells
// ---------------------------------------------------------------------------
module infix_to_postfix_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // token_kind, token_priority, token_tag, zero pad
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_tag, out_kind, status, zero pad
    output logic        m_tlast
);
    import itp_pkg::*;

    state_t state_reg, state_next;

    logic              act_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              m_valid_reg, m_valid_next;
    logic [TAG_W-1:0]  m_tag_reg;
    logic [KIND_W-1:0] m_kind_reg;
    logic [STAT_W-1:0] m_stat_reg;
    logic              m_last_reg;

    entry_t  top_e, nxt_e, push_e;
    stk_op_t stk_op;

    logic              load, run;
    logic              emit, e_last, do_pop, do_push, done, go, out_free;
    logic [TAG_W-1:0]  e_tag;
    logic [KIND_W-1:0] e_kind;
    logic [STAT_W-1:0] e_stat;
    logic              empty, full, has_two, top_pops, nxt_pops;

    // fsm outputs
    always_comb begin
        s_tready = 1'b0;
        run      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = aresetn;
            ST_RUN:  run      = 1'b1;
            default: s_tready = 1'b0;
        endcase
    end

    assign load = s_tvalid && s_tready;

    // one step of the conversion
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign has_two  = (cnt_reg > CNT_W'(1));
    assign top_pops = !empty && (top_e.kind != KIND_OPEN)
                      && ((top_e.kind == KIND_PREFIX) || (top_e.prio >= prio_reg));
    assign nxt_pops = has_two && (nxt_e.kind != KIND_OPEN)
                      && ((nxt_e.kind == KIND_PREFIX) || (nxt_e.prio >= prio_reg));

    always_comb begin
        emit    = 1'b0;
        e_tag   = tag_reg;
        e_kind  = kind_reg;
        e_stat  = STAT_TOKEN;
        e_last  = 1'b1;
        do_pop  = 1'b0;
        do_push = 1'b0;
        done    = 1'b1;
        if (act_reg) begin
            if (!empty) begin
                emit   = 1'b1;
                e_tag  = top_e.tag;
                e_kind = top_e.kind;
                e_last = (cnt_reg == CNT_W'(1));
                do_pop = 1'b1;
                done   = (cnt_reg == CNT_W'(1));
            end
        end else begin
            unique case (kind_reg) inside
                KIND_NUM, KIND_POSTFIX: begin
                    emit = 1'b1;
                end
                KIND_PREFIX, KIND_OPEN: begin
                    if (full) begin
                        emit   = 1'b1;
                        e_stat = STAT_OVERFLOW;
                    end else begin
                        do_push = 1'b1;
                    end
                end
                KIND_CLOSE: begin
                    if (empty) begin
                        emit   = 1'b1;
                        e_stat = STAT_UNMATCHED;
                    end else if (top_e.kind == KIND_OPEN) begin
                        do_pop = 1'b1;
                    end else begin
                        emit   = 1'b1;
                        e_tag  = top_e.tag;
                        e_kind = top_e.kind;
                        e_last = has_two && (nxt_e.kind == KIND_OPEN);
                        do_pop = 1'b1;
                        done   = 1'b0;
                    end
                end
                KIND_BINARY: begin
                    if (top_pops) begin
                        emit   = 1'b1;
                        e_tag  = top_e.tag;
                        e_kind = top_e.kind;
                        e_last = !nxt_pops;
                        do_pop = 1'b1;
                        done   = 1'b0;
                    end else if (full) begin
                        emit   = 1'b1;
                        e_stat = STAT_OVERFLOW;
                    end else begin
                        do_push = 1'b1;
                    end
                end
                default: begin
                    emit   = 1'b1;
                    e_stat = STAT_BAD;
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign go       = run && (!emit || out_free);

    assign stk_op.push = go && do_push;
    assign stk_op.pop  = go && do_pop;
    assign push_e      = '{prio: prio_reg, kind: kind_reg, tag: tag_reg};

    itp_stack u_stack (
        .aclk         (aclk),
        .op_i         (stk_op),
        .push_entry_i (push_e),
        .top_o        (top_e),
        .next_o       (nxt_e)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (load) state_next = ST_RUN;
            ST_RUN:  if (go && done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (stk_op.push) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (stk_op.pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (go && emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            act_reg  <= s_tuser;
            kind_reg <= s_tdata[2:0];
            prio_reg <= s_tdata[6:3];
            tag_reg  <= s_tdata[22:7];
        end
        if (go && emit) begin
            m_tag_reg  <= e_tag;
            m_kind_reg <= e_kind;
            m_stat_reg <= e_stat;
            m_last_reg <= e_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_stat_reg, m_kind_reg, m_tag_reg};
    assign m_tlast  = m_last_reg;

endmodule

@@ sv/itp_checker.sv @@
// ---------------------------------------------------------------------------
// itp_checker
// port-level checks of the infix to postfix converter
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module itp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    import itp_pkg::*;

    logic stalled;
    logic [TAG_W-1:0] unused_tag;

    assign stalled    = m_tvalid && !m_tready;
    assign unused_tag = s_tdata[22:7] ^ {15'd0, s_tuser};

    // a stalled result beat holds
    `ITP_ASSERT_NEXT(a_out_hold, stalled,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // one token in work at a time
    `ITP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready && (unused_tag == unused_tag),
        !s_tready)

    // an unmatched close ends its token and carries the close kind
    `ITP_ASSERT_IMPL(a_unmatched_close, m_tvalid && (m_tdata[20:19] == STAT_UNMATCHED),
        m_tlast && (m_tdata[18:16] == KIND_CLOSE))

    // an overflow ends its token and carries a pushable kind
    `ITP_ASSERT_IMPL(a_overflow_kind, m_tvalid && (m_tdata[20:19] == STAT_OVERFLOW),
        m_tlast && ((m_tdata[18:16] == KIND_PREFIX) || (m_tdata[18:16] == KIND_OPEN)
        || (m_tdata[18:16] == KIND_BINARY)))

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/sv/tb_infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// self-checking bench for the shunting-yard converter: classified tokens go
// in, a predictor with its own operator stack works out the postfix stream,
// overflow and error beats, and every result beat is checked in order
// ---------------------------------------------------------------------------
module tb_infix_to_postfix_converter;
    import itp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_RSVD = 3'd7;
    localparam int RANDOM_TOKENS = 440;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 50;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic              action;
        logic [KIND_W-1:0] kind;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } infix_tok_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic              last;
    } postfix_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    infix_tok_t   token_q[$];
    postfix_res_t postfix_q[$];
    postfix_res_t step_q[$];
    entry_t       op_stk[STACK_DEPTH];
    int           op_cnt      = 0;
    int           tok_total   = 0;
    int           tok_taken   = 0;
    int           pressure_at = 0;
    int           err_cnt     = 0;
    int           stall_cnt   = 0;
    int           hold_left   = 0;
    bit           hold_done   = 1'b0;
    bit           in_taken    = 1'b0;

    infix_to_postfix_converter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic void add_tok(bit act, logic [KIND_W-1:0] kind,
                                    logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
        infix_tok_t t;
        t.action = act;
        t.kind   = kind;
        t.prio   = prio;
        t.tag    = tag;
        token_q.insert(token_q.size(), t);
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [PRIO_W-1:0] rand_prio();
        return PRIO_W'($urandom_range(0, 15));
    endfunction

    function automatic void emit(logic [TAG_W-1:0] tag, logic [KIND_W-1:0] kind,
                                 logic [STAT_W-1:0] status);
        postfix_res_t r;
        r.tag    = tag;
        r.kind   = kind;
        r.status = status;
        r.last   = 1'b0;
        step_q.insert(step_q.size(), r);
    endfunction

    function automatic void push_op(entry_t e);
        if (op_cnt >= STACK_DEPTH) begin
            emit(e.tag, e.kind, STAT_OVERFLOW);
        end else begin
            op_stk[op_cnt] = e;
            op_cnt++;
        end
    endfunction

    function automatic void predict_postfix(infix_tok_t t);
        entry_t e;
        bit     matched;
        bit     stop;
        e.tag   = t.tag;
        e.kind  = t.kind;
        e.prio  = t.prio;
        matched = 1'b0;
        stop    = 1'b0;
        step_q.delete();
        if (t.action) begin
            while (op_cnt > 0) begin
                op_cnt--;
                emit(op_stk[op_cnt].tag, op_stk[op_cnt].kind, STAT_TOKEN);
            end
        end else begin
            case (t.kind)
                KIND_NUM, KIND_POSTFIX: begin
                    emit(t.tag, t.kind, STAT_TOKEN);
                end
                KIND_PREFIX, KIND_OPEN: begin
                    push_op(e);
                end
                KIND_CLOSE: begin
                    while (op_cnt > 0 && !matched) begin
                        op_cnt--;
                        if (op_stk[op_cnt].kind == KIND_OPEN)
                            matched = 1'b1;
                        else
                            emit(op_stk[op_cnt].tag, op_stk[op_cnt].kind, STAT_TOKEN);
                    end
                    if (!matched)
                        emit(t.tag, t.kind, STAT_UNMATCHED);
                end
                KIND_BINARY: begin
                    while (op_cnt > 0 && !stop) begin
                        if (op_stk[op_cnt-1].kind == KIND_OPEN)
                            stop = 1'b1;
                        else if (op_stk[op_cnt-1].kind != KIND_PREFIX &&
                                 op_stk[op_cnt-1].prio < t.prio)
                            stop = 1'b1;
                        else begin
                            op_cnt--;
                            emit(op_stk[op_cnt].tag, op_stk[op_cnt].kind, STAT_TOKEN);
                        end
                    end
                    push_op(e);
                end
                default: begin
                    emit(t.tag, t.kind, STAT_BAD);
                end
            endcase
        end
        if (step_q.size() > 0)
            step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i])
            postfix_q.insert(postfix_q.size(), step_q[i]);
    endfunction

    // well-formed expression, deep mode nests one bracket per level
    task automatic gen_expr(input int lvl, input int max_lvl, input bit deep);
        int n_terms;
        int i;
        n_terms = deep ? 1 : $urandom_range(1, 3);
        for (i = 0; i < n_terms; i++) begin
            if (i > 0)
                add_tok(1'b0, KIND_BINARY, rand_prio(), rand_tag());
            if ($urandom_range(0, 2) == 0)
                add_tok(1'b0, KIND_PREFIX, rand_prio(), rand_tag());
            if (lvl < max_lvl && (deep || $urandom_range(0, 3) == 0)) begin
                add_tok(1'b0, KIND_OPEN, rand_prio(), rand_tag());
                gen_expr(lvl + 1, max_lvl, deep);
                add_tok(1'b0, KIND_CLOSE, rand_prio(), rand_tag());
            end else begin
                add_tok(1'b0, KIND_NUM, rand_prio(), rand_tag());
            end
            if ($urandom_range(0, 3) == 0)
                add_tok(1'b0, KIND_POSTFIX, rand_prio(), rand_tag());
        end
    endtask

    function automatic int idle_pct(bit rx_side);
        if (tok_taken < tok_total / 3)
            return rx_side ? 82 : 22;
        else if (tok_taken < 2 * tok_total / 3)
            return rx_side ? 22 : 82;
        return 0;
    endfunction

    // driver
    always @(negedge aclk) begin
        bit offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            offer = token_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0);
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= {1'b0, token_q[0].tag, token_q[0].prio, token_q[0].kind};
                s_tuser <= token_q[0].action;
            end
        end
    end

    // receiver, with one long hold-off once the sender runs without gaps
    always @(negedge aclk) begin
        bit rdy;
        rdy = 1'b0;
        if (aresetn) begin
            if (!hold_done && tok_total > 0 && tok_taken >= pressure_at) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            else
                rdy = $urandom_range(0, 99) >= idle_pct(1'b1);
        end
        m_tready <= rdy;
    end

    // monitor
    always @(posedge aclk) begin
        postfix_res_t want;
        bit           out_beat;
        in_taken = aresetn && s_tvalid && s_tready;
        out_beat = aresetn && m_tvalid && m_tready;
        if (in_taken) begin
            predict_postfix(token_q.pop_front());
            tok_taken++;
        end
        if (out_beat) begin
            if (postfix_q.size() == 0) begin
                $error("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
                err_cnt++;
            end else begin
                want = postfix_q.pop_front();
                if (m_tdata[15:0] !== want.tag) begin
                    $error("out_tag: expected %h, got %h", want.tag, m_tdata[15:0]);
                    err_cnt++;
                end
                if (m_tdata[18:16] !== want.kind) begin
                    $error("out_kind: expected %0d, got %0d", want.kind, m_tdata[18:16]);
                    err_cnt++;
                end
                if (m_tdata[20:19] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[20:19]);
                    err_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    err_cnt++;
                end
            end
        end
        if (in_taken || out_beat)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int n_directed;
        int pick;
        int i;

        // corner tokens
        add_tok(1'b0, KIND_NUM, 4'd0, 16'h0000);
        add_tok(1'b0, KIND_ERROR, 4'd15, 16'hFFFF);
        add_tok(1'b0, KIND_RSVD, rand_prio(), rand_tag());
        add_tok(1'b0, KIND_CLOSE, rand_prio(), rand_tag());
        add_tok(1'b1, KIND_BINARY, rand_prio(), rand_tag());
        // binary stops at open bracket, pops prefix, matched close
        add_tok(1'b0, KIND_PREFIX, rand_prio(), rand_tag());
        add_tok(1'b0, KIND_OPEN, 4'd0, rand_tag());
        add_tok(1'b0, KIND_BINARY, 4'd15, rand_tag());
        add_tok(1'b0, KIND_CLOSE, 4'd0, rand_tag());
        add_tok(1'b0, KIND_BINARY, 4'd0, rand_tag());
        add_tok(1'b0, KIND_OPEN, 4'd0, rand_tag());
        add_tok(1'b0, KIND_CLOSE, 4'd0, rand_tag());
        add_tok(1'b0, KIND_POSTFIX, rand_prio(), rand_tag());
        // fill the stack, overflow it, then drain it all through an unmatched close
        for (i = 0; i < STACK_DEPTH - 1; i++)
            add_tok(1'b0, KIND_PREFIX, rand_prio(), rand_tag());
        add_tok(1'b0, KIND_OPEN, 4'd0, rand_tag());
        add_tok(1'b0, KIND_CLOSE, 4'd0, rand_tag());
        n_directed = token_q.size();

        while (token_q.size() < n_directed + RANDOM_TOKENS) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                gen_expr(0, 3, 1'b0);
                if ($urandom_range(0, 7) != 0)
                    add_tok(1'b1, KIND_NUM + 3'($urandom_range(0, 7)), rand_prio(), rand_tag());
            end else if (pick < 17) begin
                gen_expr(0, $urandom_range(12, 20), 1'b1);
                if ($urandom_range(0, 1) != 0)
                    add_tok(1'b1, KIND_NUM, rand_prio(), rand_tag());
            end else begin
                repeat ($urandom_range(1, 4))
                    add_tok($urandom_range(0, 4) == 0, KIND_W'($urandom_range(0, 7)),
                            rand_prio(), rand_tag());
            end
        end
        add_tok(1'b1, KIND_NUM, rand_prio(), rand_tag());

        tok_total   = token_q.size();
        pressure_at = 2 * tok_total / 3 + 10;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (tok_taken < tok_total || postfix_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
